/* rtl/ctt_pkg.sv */
// Package: shared constants, codes and the table entry type for the cone track table.
`timescale 1ns / 1ps

package ctt_pkg;

    localparam int CTT_CAPACITY = 64;
    localparam logic [15:0] TOL_RESET = 16'd256;

    localparam logic [1:0] FN_ADD   = 2'd0;
    localparam logic [1:0] FN_PRUNE = 2'd1;
    localparam logic [1:0] FN_MERGE = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    localparam logic [2:0] ST_MERGED    = 3'd0;
    localparam logic [2:0] ST_APPENDED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DONE      = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_BAD_INDEX = 3'd5;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        size;
        logic [31:0]        stamp;
    } entry_t;

endpackage

/* rtl/ctt_req_if.sv */
// Interface: request channel of the cone track table.
`timescale 1ns / 1ps

interface ctt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        cone_size;
    logic [31:0]        cone_time;
    logic [15:0]        keep_radius;
    logic [5:0]         read_slot;

    modport source (output valid, func, pos_x, pos_y, cone_size, cone_time, keep_radius,
                    read_slot, input ready);
    modport sink (input valid, func, pos_x, pos_y, cone_size, cone_time, keep_radius,
                  read_slot, output ready);
endinterface

/* rtl/ctt_rsp_if.sv */
// Interface: response channel of the cone track table.
`timescale 1ns / 1ps

interface ctt_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [5:0]         slot;
    logic [6:0]         entry_count;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_size;
    logic [31:0]        out_time;

    modport source (output valid, status, slot, entry_count, out_x, out_y, out_size,
                    out_time, input ready);
    modport sink (input valid, status, slot, entry_count, out_x, out_y, out_size,
                  out_time, output ready);
endinterface

/* rtl/cone_track_table.sv */
// Cone track table: stores detected cones and associates new detections by distance.
//
// Requests arrive on req (valid/ready); each request gives exactly one response on rsp.
// func selects add, prune, merge or read. merge_tolerance is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, as the block itself
// does not enforce this. One request is worked at a time; req.ready is high only in the
// idle state. A single 17x17 squaring multiplier and one single-port table memory
// (registered read) are reused under a sequencer that visits each entry through S_RD,
// S_DX, S_DY and S_CMP. Add and prune visit every entry; merge scans the pairs of
// entries, shifts the later entries down on each removal, and restarts the pair scan
// from the first entry after every removal. req.ready returns in the same cycle that
// the response is registered.
// The response sits in an output register; the next request is taken while it waits,
// but that request's response stalls until rsp.ready takes the previous one.
// Reset empties the table (count zero, tolerance 256); stored entries are not cleared
// and are never read until written.
`timescale 1ns / 1ps

module cone_track_table #(
    parameter int CAPACITY = ctt_pkg::CTT_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    ctt_req_if.sink     req,
    ctt_rsp_if.source   rsp
);
    import ctt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + 6;

    typedef enum logic [3:0] {
        S_IDLE, S_LIM, S_LIM2, S_READ, S_RD, S_DX, S_DY, S_CMP,
        S_ADD, S_MI, S_MCAP, S_SH, S_SH_WR, S_RESP
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [15:0]        tol_reg;

    logic [1:0]         func_reg;
    logic signed [15:0] ref_x_reg;
    logic signed [15:0] ref_y_reg;
    logic [15:0]        size_reg;
    logic [31:0]        time_reg;
    logic [15:0]        krad_reg;
    logic [5:0]         rslot_reg;

    logic [31:0]        mul_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        lim_reg;
    logic [32:0]        best_d_reg;
    logic [IDX_W-1:0]   best_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   m_reg;
    logic [CNT_W-1:0]   w_reg;
    logic [31:0]        ti_reg;

    logic [2:0]         res_status_reg;
    logic [5:0]         res_slot_reg;
    entry_t             res_data_reg;

    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [5:0]         out_slot_reg;
    logic [6:0]         out_count_reg;
    entry_t             out_data_reg;

    entry_t             mem [CAPACITY];
    entry_t             rd_data_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;

    logic signed [16:0] mul_a;
    logic signed [33:0] mul_next;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [32:0]        dist_sum;
    logic               close;
    logic               keep;
    logic               scan_last;
    logic               add_merge;
    logic               read_ok;
    entry_t             req_entry;

    assign dx = $signed({ref_x_reg[15], ref_x_reg}) - $signed({rd_data_reg.x[15], rd_data_reg.x});
    assign dy = $signed({ref_y_reg[15], ref_y_reg}) - $signed({rd_data_reg.y[15], rd_data_reg.y});
    assign dist_sum = {1'b0, acc_reg} + {1'b0, mul_reg};
    assign close = dist_sum < {1'b0, lim_reg};
    assign keep = dist_sum <= {1'b0, lim_reg};
    assign scan_last = (CNT_W'(j_reg) + 1'b1) >= count_reg;
    assign add_merge = (count_reg != '0) && (best_d_reg < {1'b0, lim_reg});
    assign read_ok = CMP_W'(rslot_reg) < CMP_W'(count_reg);
    assign req_entry = '{x: ref_x_reg, y: ref_y_reg, size: size_reg, stamp: time_reg};

    // Shared squaring unit
    always_comb
    begin
        unique case (state_reg)
            S_LIM:   mul_a = (func_reg == FN_PRUNE) ? {1'b0, krad_reg} : {1'b0, tol_reg};
            S_DX:    mul_a = dx;
            S_DY:    mul_a = dy;
            default: mul_a = '0;
        endcase
    end
    assign mul_next = mul_a * mul_a;

    // Memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = j_reg;
        wr_en   = 1'b0;
        wr_addr = w_reg[IDX_W-1:0];
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_LIM2:
            begin
                rd_en   = (func_reg == FN_READ) && read_ok;
                rd_addr = IDX_W'(rslot_reg);
            end
            S_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg;
            end
            S_MI:
            begin
                rd_en   = 1'b1;
                rd_addr = i_reg;
            end
            S_SH:
            begin
                rd_en   = (CNT_W'(m_reg) + 1'b1) < count_reg;
                rd_addr = IDX_W'(CNT_W'(m_reg) + 1'b1);
            end
            S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = m_reg;
            end
            S_CMP:
            begin
                wr_en   = (func_reg == FN_PRUNE) && keep;
                wr_addr = w_reg[IDX_W-1:0];
            end
            S_ADD:
            begin
                wr_data = req_entry;
                if (add_merge)
                begin
                    wr_en   = 1'b1;
                    wr_addr = best_reg;
                end
                else if (count_reg < CNT_W'(CAPACITY))
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[IDX_W-1:0];
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot        = out_slot_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.out_x       = out_data_reg.x;
    assign rsp.out_y       = out_data_reg.y;
    assign rsp.out_size    = out_data_reg.size;
    assign rsp.out_time    = out_data_reg.stamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (out_valid_reg && rsp.ready && state_reg != S_RESP)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        func_reg       <= req.func;
                        ref_x_reg      <= req.pos_x;
                        ref_y_reg      <= req.pos_y;
                        size_reg       <= req.cone_size;
                        time_reg       <= req.cone_time;
                        krad_reg       <= req.keep_radius;
                        rslot_reg      <= req.read_slot;
                        res_status_reg <= ST_DONE;
                        res_slot_reg   <= '0;
                        res_data_reg   <= '0;
                        state_reg      <= S_LIM;
                    end
                end
                S_LIM:
                begin
                    mul_reg   <= mul_next[31:0];
                    state_reg <= S_LIM2;
                end
                S_LIM2:
                begin
                    lim_reg <= mul_reg;
                    j_reg   <= '0;
                    i_reg   <= '0;
                    w_reg   <= '0;
                    unique case (func_reg)
                        FN_ADD:   state_reg <= (count_reg == '0) ? S_ADD : S_RD;
                        FN_PRUNE: state_reg <= (count_reg == '0) ? S_RESP : S_RD;
                        FN_MERGE: state_reg <= S_MI;
                        default:
                        begin
                            res_slot_reg <= rslot_reg;
                            if (read_ok)
                                state_reg <= S_READ;
                            else
                            begin
                                res_status_reg <= ST_BAD_INDEX;
                                state_reg      <= S_RESP;
                            end
                        end
                    endcase
                end
                S_READ:
                begin
                    res_status_reg <= ST_READ_OK;
                    res_data_reg   <= rd_data_reg;
                    state_reg      <= S_RESP;
                end
                S_RD:
                begin
                    state_reg <= S_DX;
                end
                S_DX:
                begin
                    mul_reg   <= mul_next[31:0];
                    state_reg <= S_DY;
                end
                S_DY:
                begin
                    acc_reg   <= mul_reg;
                    mul_reg   <= mul_next[31:0];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    case (func_reg)
                        FN_ADD:
                        begin
                            if (j_reg == '0 || dist_sum < best_d_reg)
                            begin
                                best_d_reg <= dist_sum;
                                best_reg   <= j_reg;
                            end
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= scan_last ? S_ADD : S_RD;
                        end
                        FN_PRUNE:
                        begin
                            if (keep)
                                w_reg <= w_reg + 1'b1;
                            j_reg <= j_reg + 1'b1;
                            if (scan_last)
                            begin
                                count_reg <= w_reg + CNT_W'(keep);
                                state_reg <= S_RESP;
                            end
                            else
                                state_reg <= S_RD;
                        end
                        default:
                        begin
                            if (close)
                            begin
                                // drop the older cone, the second one on equal stamps
                                m_reg     <= (ti_reg < rd_data_reg.stamp) ? i_reg : j_reg;
                                state_reg <= S_SH;
                            end
                            else if (!scan_last)
                            begin
                                j_reg     <= j_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= S_MI;
                            end
                        end
                    endcase
                end
                S_ADD:
                begin
                    if (add_merge)
                    begin
                        res_status_reg <= ST_MERGED;
                        res_slot_reg   <= 6'(best_reg);
                    end
                    else if (count_reg < CNT_W'(CAPACITY))
                    begin
                        res_status_reg <= ST_APPENDED;
                        res_slot_reg   <= 6'(count_reg);
                        count_reg      <= count_reg + 1'b1;
                    end
                    else
                        res_status_reg <= ST_FULL;
                    state_reg <= S_RESP;
                end
                S_MI:
                begin
                    if ((CNT_W'(i_reg) + 1'b1) >= count_reg)
                        state_reg <= S_RESP;
                    else
                        state_reg <= S_MCAP;
                end
                S_MCAP:
                begin
                    ref_x_reg <= rd_data_reg.x;
                    ref_y_reg <= rd_data_reg.y;
                    ti_reg    <= rd_data_reg.stamp;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= S_RD;
                end
                S_SH:
                begin
                    if ((CNT_W'(m_reg) + 1'b1) < count_reg)
                        state_reg <= S_SH_WR;
                    else
                    begin
                        // restart the pair scan from the first entry
                        count_reg <= count_reg - 1'b1;
                        i_reg     <= '0;
                        state_reg <= S_MI;
                    end
                end
                S_SH_WR:
                begin
                    m_reg     <= m_reg + 1'b1;
                    state_reg <= S_SH;
                end
                S_RESP:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_slot_reg   <= res_slot_reg;
                        out_count_reg  <= 7'(count_reg);
                        out_data_reg   <= res_data_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while busy");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> CNT_W'(wr_addr) <= count_reg)
        else $error("table write beyond fill level");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD && !add_merge && count_reg < CNT_W'(CAPACITY)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the table");

    a_resp_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && out_valid_reg && !rsp.ready |=> out_valid_reg)
        else $error("pending response lost");

endmodule

/* verif/cone_track_table_tb.sv */
// Testbench: drives directed and random cone requests and checks every response against a predictor.
`timescale 1ns / 1ps

module cone_track_table_tb;
    import ctt_pkg::*;

    typedef struct {
        logic [1:0]         func;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        cone_size;
        logic [31:0]        cone_time;
        logic [15:0]        keep_radius;
        logic [5:0]         read_slot;
    } cone_req_t;

    typedef struct {
        logic [2:0]         status;
        logic [5:0]         slot;
        logic [6:0]         entry_count;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [15:0]        out_size;
        logic [31:0]        out_time;
    } cone_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    ctt_req_if req ();
    ctt_rsp_if rsp ();

    cone_track_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // predictor state
    entry_t      table_model [CTT_CAPACITY];
    int          model_count;
    logic [15:0] model_tol;

    cone_req_t pending_reqs[$];
    cone_rsp_t expected_rsps[$];
    int        error_count;
    int        hold_off;
    int        req_gap;
    int        rsp_gap;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [33:0] dist2(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] bx, logic signed [15:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return 34'(dx * dx + dy * dy);
    endfunction

    function automatic void drop_entry(int k);
        for (int m = k; m + 1 < model_count; m++)
            table_model[m] = table_model[m + 1];
        model_count--;
    endfunction

    function automatic cone_rsp_t predict_cone_table(cone_req_t r);
        cone_rsp_t   o;
        logic [33:0] tol2;
        logic [33:0] d;
        logic [33:0] bestd;
        logic [33:0] r2;
        int          best;
        int          w;
        bit          again;
        entry_t      e;
        o = '{status: ST_DONE, slot: 6'd0, entry_count: 7'd0, out_x: 16'sd0,
              out_y: 16'sd0, out_size: 16'd0, out_time: 32'd0};
        tol2 = 34'(model_tol) * 34'(model_tol);
        e.x = r.pos_x;
        e.y = r.pos_y;
        e.size = r.cone_size;
        e.stamp = r.cone_time;
        case (r.func)
            FN_ADD:
            begin
                best = -1;
                bestd = '0;
                for (int i = 0; i < model_count; i++)
                begin
                    d = dist2(r.pos_x, r.pos_y, table_model[i].x, table_model[i].y);
                    if (best < 0 || d < bestd)
                    begin
                        best = i;
                        bestd = d;
                    end
                end
                if (best >= 0 && bestd < tol2)
                begin
                    table_model[best] = e;
                    o.status = ST_MERGED;
                    o.slot = 6'(best);
                end
                else if (model_count < CTT_CAPACITY)
                begin
                    table_model[model_count] = e;
                    o.status = ST_APPENDED;
                    o.slot = 6'(model_count);
                    model_count++;
                end
                else
                    o.status = ST_FULL;
            end
            FN_PRUNE:
            begin
                r2 = 34'(r.keep_radius) * 34'(r.keep_radius);
                w = 0;
                for (int i = 0; i < model_count; i++)
                    if (dist2(table_model[i].x, table_model[i].y, r.pos_x, r.pos_y) <= r2)
                    begin
                        table_model[w] = table_model[i];
                        w++;
                    end
                model_count = w;
            end
            FN_MERGE:
            begin
                again = 1'b1;
                while (again)
                begin
                    again = 1'b0;
                    for (int i = 0; i < model_count && !again; i++)
                        for (int j = i + 1; j < model_count && !again; j++)
                            if (dist2(table_model[i].x, table_model[i].y,
                                      table_model[j].x, table_model[j].y) < tol2)
                            begin
                                drop_entry(table_model[i].stamp < table_model[j].stamp
                                           ? i : j);
                                again = 1'b1;
                            end
                end
            end
            default:
            begin
                o.slot = r.read_slot;
                if (int'(r.read_slot) < model_count)
                begin
                    o.status = ST_READ_OK;
                    o.out_x = table_model[r.read_slot].x;
                    o.out_y = table_model[r.read_slot].y;
                    o.out_size = table_model[r.read_slot].size;
                    o.out_time = table_model[r.read_slot].stamp;
                end
                else
                    o.status = ST_BAD_INDEX;
            end
        endcase
        o.entry_count = 7'(model_count);
        return o;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req_gap <= 0;
        end
        else if (req.valid && !req.ready)
        begin
            // hold
        end
        else if (req_gap > 0)
        begin
            req.valid <= 1'b0;
            req_gap <= req_gap - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            cone_req_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(predict_cone_table(r));
            req.valid <= 1'b1;
            req.func <= r.func;
            req.pos_x <= r.pos_x;
            req.pos_y <= r.pos_y;
            req.cone_size <= r.cone_size;
            req.cone_time <= r.cone_time;
            req.keep_radius <= r.keep_radius;
            req.read_slot <= r.read_slot;
            req_gap <= pick_gap();
        end
        else
            req.valid <= 1'b0;
    end

    // response stall control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_gap <= 0;
        end
        else if (hold_off > 0)
        begin
            rsp.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (rsp_gap > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (!(rsp.valid && rsp.ready))
                rsp_gap <= 0;
            else
                rsp_gap <= pick_gap();
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response status=%0d", rsp.status);
                error_count++;
            end
            else
            begin
                cone_rsp_t x;
                x = expected_rsps.pop_front();
                if (rsp.status !== x.status)
                begin
                    $error("status: expected %0d, got %0d", x.status, rsp.status);
                    error_count++;
                end
                if (rsp.slot !== x.slot)
                begin
                    $error("slot: expected %0d, got %0d", x.slot, rsp.slot);
                    error_count++;
                end
                if (rsp.entry_count !== x.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", x.entry_count,
                           rsp.entry_count);
                    error_count++;
                end
                if (rsp.out_x !== x.out_x)
                begin
                    $error("out_x: expected %0d, got %0d", x.out_x, rsp.out_x);
                    error_count++;
                end
                if (rsp.out_y !== x.out_y)
                begin
                    $error("out_y: expected %0d, got %0d", x.out_y, rsp.out_y);
                    error_count++;
                end
                if (rsp.out_size !== x.out_size)
                begin
                    $error("out_size: expected %0d, got %0d", x.out_size, rsp.out_size);
                    error_count++;
                end
                if (rsp.out_time !== x.out_time)
                begin
                    $error("out_time: expected %0d, got %0d", x.out_time, rsp.out_time);
                    error_count++;
                end
            end
        end
    end

    function automatic cone_req_t make_req(logic [1:0] f, int x, int y, int sz, int tm,
                                           int kr, int rs);
        cone_req_t r;
        r.func = f;
        r.pos_x = 16'(x);
        r.pos_y = 16'(y);
        r.cone_size = 16'(sz);
        r.cone_time = 32'(tm);
        r.keep_radius = 16'(kr);
        r.read_slot = 6'(rs);
        return r;
    endfunction

    // random request, clustered around a few spots so adds and merges hit
    function automatic cone_req_t rand_req(int spread);
        cone_req_t r;
        int roll;
        int cx;
        int cy;
        roll = $urandom_range(0, 99);
        cx = ($urandom_range(0, 3) - 2) * 1500;
        cy = ($urandom_range(0, 3) - 2) * 1500;
        r.pos_x = 16'(cx + int'($urandom_range(0, 2 * spread)) - spread);
        r.pos_y = 16'(cy + int'($urandom_range(0, 2 * spread)) - spread);
        if ($urandom_range(0, 19) == 0)
        begin
            r.pos_x = 16'($urandom);
            r.pos_y = 16'($urandom);
        end
        r.cone_size = 16'($urandom);
        r.cone_time = $urandom;
        r.keep_radius = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(1000, 6000));
        r.read_slot = 6'($urandom);
        if (roll < 60)
            r.func = FN_ADD;
        else if (roll < 66)
            r.func = FN_PRUNE;
        else if (roll < 72)
            r.func = FN_MERGE;
        else
            r.func = FN_READ;
        return r;
    endfunction

    task automatic wait_drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req.valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tol(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        model_tol = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] tols [4];
        error_count = 0;
        hold_off = 0;
        model_count = 0;
        model_tol = TOL_RESET;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, ties, equal stamps, bad index
        pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_MERGE, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_PRUNE, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, -32768, -32768, 65535, -1, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 32767, 32767, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 32767, -32768, 1, 5, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 32767, 32767, 7, 9, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 100, 0, 2, 5, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 400, 0, 3, 5, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 250, 0, 4, 6, 0, 0));
        pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 4));
        pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 63));
        pending_reqs.push_back(make_req(FN_PRUNE, -32768, -32768, 0, 0, 65535, 0));
        pending_reqs.push_back(make_req(FN_PRUNE, 0, 0, 0, 0, 400, 0));
        pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 1));
        wait_drain();
        write_tol(16'd0);
        pending_reqs.push_back(make_req(FN_ADD, 100, 0, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(FN_ADD, 100, 0, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(FN_MERGE, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 2));
        // equal stamps: second of the pair goes
        pending_reqs.push_back(make_req(FN_ADD, 110, 0, 9, 1, 0, 0));
        wait_drain();
        write_tol(16'd65535);
        pending_reqs.push_back(make_req(FN_MERGE, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(FN_READ, 0, 0, 0, 0, 0, 0));
        wait_drain();

        // fill the table to capacity, then overflow, with zero tolerance
        write_tol(16'd0);
        for (int i = 0; i < CTT_CAPACITY + 6; i++)
        begin
            cone_req_t r;
            r = rand_req(600);
            r.func = FN_ADD;
            pending_reqs.push_back(r);
        end
        // hold off responses so the block backs up its input
        hold_off = 400;
        wait_drain();
        for (int i = 0; i < 150; i++)
            pending_reqs.push_back(rand_req(600));
        wait_drain();

        tols[0] = 16'd256;
        tols[1] = 16'd40;
        tols[2] = 16'd900;
        tols[3] = 16'd3000;
        for (int p = 0; p < 16; p++)
        begin
            write_tol(tols[p % 4]);
            if (p % 4 == 1)
                pending_reqs.push_back(make_req(FN_PRUNE, 0, 0, 0, 0, 0, 0));
            for (int i = 0; i < 100; i++)
                pending_reqs.push_back(rand_req(p % 2 == 0 ? 400 : 1500));
            wait_drain();
        end

        if (error_count == 0)
            $display("cone_track_table_tb: clean");
        else
            $display("cone_track_table_tb: errors");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("cone_track_table_tb: errors");
        $finish;
    end
endmodule
